[hdl/nfpp_pkg.sv]
// nfpp_pkg: shared types, constants and helper functions of the next-fit page packer
`default_nettype none
package nfpp_pkg;

    // fixed field widths
    localparam int unsigned COUNT_W    = 20;
    localparam int unsigned INDEX_W    = 24;
    localparam int unsigned BYTES_W    = 40;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned BUDGET_W   = 32;
    // cluster size estimate fits in 30 bits for up to 256 bytes per vertex
    localparam int unsigned CL_BYTES_W = 30;

    localparam logic [CL_BYTES_W-1:0] TRI_BYTES        = CL_BYTES_W'(12);
    localparam logic [CL_BYTES_W-1:0] CLUSTER_OVERHEAD = CL_BYTES_W'(64);
    localparam logic [BUDGET_W-1:0]   BUDGET_RESET     = BUDGET_W'(65536);
    localparam logic [BYTES_W-1:0]    BYTES_MAX        = {BYTES_W{1'b1}};
    localparam logic [INDEX_W-1:0]    COUNT_MAX        = {INDEX_W{1'b1}};

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // result kinds
    localparam logic KIND_PLACEMENT = 1'b0;
    localparam logic KIND_RECORD    = 1'b1;

    // back-end phase of the head request
    typedef enum logic [1:0] {
        PH_PLACE = 2'b01,
        PH_FINAL = 2'b10
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        triangle_count;
        logic [COUNT_W-1:0]        vertex_count;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
        logic                      final_cluster;
    } in_item_t;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        page_number;
        logic [INDEX_W-1:0]        first_cluster;
        logic [INDEX_W-1:0]        clusters_in_page;
        logic [BYTES_W-1:0]        page_bytes;
        logic signed [COORD_W-1:0] page_min_x;
        logic signed [COORD_W-1:0] page_min_y;
        logic signed [COORD_W-1:0] page_min_z;
        logic signed [COORD_W-1:0] page_max_x;
        logic signed [COORD_W-1:0] page_max_y;
        logic signed [COORD_W-1:0] page_max_z;
        logic                      run_end;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    // classified cluster waiting for the back end
    typedef struct packed {
        logic [CL_BYTES_W-1:0] cluster_bytes;
        box_t                  box;
        logic                  final_cluster;
    } queue_item_t;

    localparam box_t BOX_EMPTY = '{
        min_x: COORD_MAX, min_y: COORD_MAX, min_z: COORD_MAX,
        max_x: COORD_MIN, max_y: COORD_MIN, max_z: COORD_MIN
    };

    // grow a page box by one cluster box
    function automatic box_t merge_box(input box_t page, input box_t cl);
        box_t r;
        r       = page;
        if ($signed(cl.min_x) < $signed(page.min_x)) r.min_x = cl.min_x;
        if ($signed(cl.min_y) < $signed(page.min_y)) r.min_y = cl.min_y;
        if ($signed(cl.min_z) < $signed(page.min_z)) r.min_z = cl.min_z;
        if ($signed(cl.max_x) > $signed(page.max_x)) r.max_x = cl.max_x;
        if ($signed(cl.max_y) > $signed(page.max_y)) r.max_y = cl.max_y;
        if ($signed(cl.max_z) > $signed(page.max_z)) r.max_z = cl.max_z;
        return r;
    endfunction

    function automatic out_item_t make_record(
        input logic [INDEX_W-1:0] number,
        input logic [INDEX_W-1:0] first,
        input logic [INDEX_W-1:0] clusters,
        input logic [BYTES_W-1:0] bytes,
        input box_t               box,
        input logic               last
    );
        out_item_t r;
        r.kind             = KIND_RECORD;
        r.page_number      = number;
        r.first_cluster    = first;
        r.clusters_in_page = clusters;
        r.page_bytes       = bytes;
        r.page_min_x       = box.min_x;
        r.page_min_y       = box.min_y;
        r.page_min_z       = box.min_z;
        r.page_max_x       = box.max_x;
        r.page_max_y       = box.max_y;
        r.page_max_z       = box.max_z;
        r.run_end          = last;
        return r;
    endfunction

    function automatic out_item_t make_placement(
        input logic [INDEX_W-1:0] number,
        input logic [INDEX_W-1:0] index,
        input logic               last
    );
        out_item_t r;
        r               = '0;
        r.kind          = KIND_PLACEMENT;
        r.page_number   = number;
        r.first_cluster = index;
        r.run_end       = last;
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/nfpp_front.sv]
// nfpp_front: accepts cluster requests and computes their byte estimate
`default_nettype none
module nfpp_front
    import nfpp_pkg::*;
#(
    parameter int unsigned VERTEX_BYTES = 48
) (
    input  wire in_item_t    s_data,
    output queue_item_t      q_item
);

    logic [CL_BYTES_W-1:0] tri_part;
    logic [CL_BYTES_W-1:0] vert_part;

    // size estimate: triangles * 12 + vertices * VERTEX_BYTES + overhead
    assign tri_part  = CL_BYTES_W'(s_data.triangle_count) * TRI_BYTES;
    assign vert_part = CL_BYTES_W'(s_data.vertex_count) * CL_BYTES_W'(VERTEX_BYTES);

    always_comb begin
        q_item.cluster_bytes = tri_part + vert_part + CLUSTER_OVERHEAD;
        q_item.box.min_x     = s_data.box_min_x;
        q_item.box.min_y     = s_data.box_min_y;
        q_item.box.min_z     = s_data.box_min_z;
        q_item.box.max_x     = s_data.box_max_x;
        q_item.box.max_y     = s_data.box_max_y;
        q_item.box.max_z     = s_data.box_max_z;
        q_item.final_cluster = s_data.final_cluster;
    end

endmodule
`default_nettype wire

[hdl/nfpp_queue.sv]
// nfpp_queue: small fifo between the classifying front and the packing back end
`default_nettype none
module nfpp_queue
    import nfpp_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire queue_item_t push_item,
    output logic             full,
    input  wire              pop,
    output logic             head_valid,
    output queue_item_t      head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    queue_item_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[hdl/nfpp_back.sv]
// nfpp_back: open-page state, next-fit decision and result register
`default_nettype none
module nfpp_back
    import nfpp_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [BUDGET_W-1:0]   target_page_bytes,
    input  wire                  head_valid,
    input  wire queue_item_t     head_item,
    output logic                 pop,
    output logic                 in_final,
    output logic                 m_valid,
    input  wire                  m_ready,
    output out_item_t            m_data
);

    phase_t             phase_reg, phase_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [INDEX_W-1:0] clusters_reg, clusters_next;
    logic [INDEX_W-1:0] first_reg, first_next;
    logic [INDEX_W-1:0] number_reg, number_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    box_t               box_reg, box_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic [BYTES_W:0]   sum;
    logic               need_close;
    logic               out_free;
    logic               step;

    assign out_free   = !m_valid_reg || m_ready;
    assign step       = head_valid && out_free;
    assign sum        = {1'b0, bytes_reg} + (BYTES_W + 1)'(head_item.cluster_bytes);
    assign need_close = (clusters_reg != '0) &&
                        (sum > (BYTES_W + 1)'(target_page_bytes));
    assign in_final   = (phase_reg == PH_FINAL);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // one result per cycle for the head request while the result register is free
    always_comb begin
        phase_next    = phase_reg;
        bytes_next    = bytes_reg;
        clusters_next = clusters_reg;
        first_next    = first_reg;
        number_next   = number_reg;
        index_next    = index_reg;
        box_next      = box_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        pop           = 1'b0;
        if (out_free) begin
            m_valid_next = step;
        end
        if (step) begin
            case (phase_reg)
                PH_PLACE: begin
                    if (need_close) begin
                        // overflow: close the open page and start a fresh one
                        m_data_next   = make_record(number_reg, first_reg, clusters_reg,
                                                    bytes_reg, box_reg, 1'b0);
                        number_next   = number_reg + 1'b1;
                        first_next    = index_reg;
                        bytes_next    = '0;
                        clusters_next = '0;
                        box_next      = BOX_EMPTY;
                    end else begin
                        // place the cluster in the open page
                        m_data_next   = make_placement(number_reg, index_reg,
                                                       !head_item.final_cluster);
                        clusters_next = (clusters_reg == COUNT_MAX) ? clusters_reg
                                                                    : clusters_reg + 1'b1;
                        bytes_next    = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
                        box_next      = merge_box(box_reg, head_item.box);
                        index_next    = index_reg + 1'b1;
                        if (head_item.final_cluster) begin
                            phase_next = PH_FINAL;
                        end else begin
                            pop = 1'b1;
                        end
                    end
                end
                PH_FINAL: begin
                    // last cluster: emit the final page and restart
                    m_data_next   = make_record(number_reg, first_reg, clusters_reg,
                                                bytes_reg, box_reg, 1'b1);
                    bytes_next    = '0;
                    clusters_next = '0;
                    first_next    = '0;
                    number_next   = '0;
                    index_next    = '0;
                    box_next      = BOX_EMPTY;
                    phase_next    = PH_PLACE;
                    pop           = 1'b1;
                end
                default: begin
                    phase_next = PH_PLACE;
                end
            endcase
        end
    end

    // control and page state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_PLACE;
            bytes_reg    <= '0;
            clusters_reg <= '0;
            first_reg    <= '0;
            number_reg   <= '0;
            index_reg    <= '0;
            box_reg      <= BOX_EMPTY;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            bytes_reg    <= bytes_next;
            clusters_reg <= clusters_next;
            first_reg    <= first_next;
            number_reg   <= number_next;
            index_reg    <= index_next;
            box_reg      <= box_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

[hdl/next_fit_page_packer.sv]
// next_fit_page_packer: top level of the next-fit cluster page packer
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   in_item_t   one cluster request
//   m_        out        m_valid / m_ready   out_item_t  placement or page record
//   cfg_      in         cfg_we              cfg_wdata   target_page_bytes
//
// a request yields one to three results, one result per cycle unless m_ready stalls;
// requests that only place their cluster go at one request per cycle unless a page
// closes or m_ready stalls. the single result register in the back end sets that pace.
// the front computes the size estimate in the accept cycle and writes a QUEUE_DEPTH fifo.
// reset is synchronous, active low; no clearing pass is needed.
// s_ready drops only while the fifo is full; m_ready low stalls the back end only.
`default_nettype none
module next_fit_page_packer
    import nfpp_pkg::*;
#(
    parameter int unsigned VERTEX_BYTES = 48,
    parameter int unsigned QUEUE_DEPTH  = 2
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire in_item_t      s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output out_item_t          m_data,
    input  wire                cfg_we,
    input  wire [BUDGET_W-1:0] cfg_wdata
);

    logic [BUDGET_W-1:0] target_reg;
    queue_item_t         cls_item;
    queue_item_t         head_item;
    logic                q_full;
    logic                head_valid;
    logic                pop;
    logic                in_final;

    // page budget register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= BUDGET_RESET;
        end else if (cfg_we) begin
            target_reg <= cfg_wdata;
        end
    end

    assign s_ready = !q_full;

    nfpp_front #(
        .VERTEX_BYTES(VERTEX_BYTES)
    ) u_front (
        .s_data (s_data),
        .q_item (cls_item)
    );

    nfpp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_item  (cls_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    nfpp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .target_page_bytes (target_reg),
        .head_valid        (head_valid),
        .head_item         (head_item),
        .pop               (pop),
        .in_final          (in_final),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data)
    );

`ifndef NO_ASSERTIONS
    // the final record is pending only while its request is still queued
    a_final_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        in_final |-> head_valid)
        else $error("final phase without a queued request");

    // placements carry no page totals
    a_placement_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_PLACEMENT) |->
            (m_data.clusters_in_page == '0 && m_data.page_bytes == '0))
        else $error("placement with page totals");

    // a closed page always holds at least one cluster
    a_record_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_RECORD) |-> (m_data.clusters_in_page != '0))
        else $error("empty page record");
`endif

endmodule
`default_nettype wire

[tb/next_fit_page_packer_tb.sv]
// next_fit_page_packer_tb: self-checking testbench of the next-fit cluster page packer
`default_nettype none
module next_fit_page_packer_tb;
    import nfpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VERTEX_BYTES = 48;
    localparam logic signed [COORD_W-1:0] LO_EMPTY = 32'h7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] HI_EMPTY = 32'h8000_0000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    out_item_t           m_data;
    logic                cfg_we = 1'b0;
    logic [BUDGET_W-1:0] cfg_wdata = '0;

    next_fit_page_packer #(
        .VERTEX_BYTES(VERTEX_BYTES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // packer state as the testbench tracks it
    logic [BUDGET_W-1:0]       page_budget;
    logic [BYTES_W-1:0]        open_bytes;
    logic [INDEX_W-1:0]        open_clusters;
    logic [INDEX_W-1:0]        open_first;
    logic [INDEX_W-1:0]        open_number;
    logic [INDEX_W-1:0]        next_index;
    logic signed [COORD_W-1:0] page_lo [3];
    logic signed [COORD_W-1:0] page_hi [3];

    out_item_t pending_results [$];
    out_item_t oldest_result;
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;

    // empty page box and counters
    task automatic clear_page();
        open_bytes    = '0;
        open_clusters = '0;
        for (int i = 0; i < 3; i++) begin
            page_lo[i] = LO_EMPTY;
            page_hi[i] = HI_EMPTY;
        end
    endtask

    task automatic restart_packer();
        clear_page();
        open_first  = '0;
        open_number = '0;
        next_index  = '0;
    endtask

    // append one expected result at the tail
    task automatic expect_result(input out_item_t r);
        pending_results = {pending_results, r};
    endtask

    function automatic out_item_t page_record(input logic last);
        out_item_t r;
        r.kind             = KIND_RECORD;
        r.page_number      = open_number;
        r.first_cluster    = open_first;
        r.clusters_in_page = open_clusters;
        r.page_bytes       = open_bytes;
        r.page_min_x       = page_lo[0];
        r.page_min_y       = page_lo[1];
        r.page_min_z       = page_lo[2];
        r.page_max_x       = page_hi[0];
        r.page_max_y       = page_hi[1];
        r.page_max_z       = page_hi[2];
        r.run_end          = last;
        return r;
    endfunction

    // place one accepted cluster and queue the results it causes
    task automatic place_cluster(input in_item_t c);
        logic [63:0]               cl_bytes;
        logic [63:0]               sum;
        logic signed [COORD_W-1:0] cl_lo [3];
        logic signed [COORD_W-1:0] cl_hi [3];
        out_item_t                 placed;
        cl_bytes = 64'(c.triangle_count) * 64'd12 + 64'(c.vertex_count) * 64'(VERTEX_BYTES)
                 + 64'd64;
        cl_lo = '{c.box_min_x, c.box_min_y, c.box_min_z};
        cl_hi = '{c.box_max_x, c.box_max_y, c.box_max_z};
        // overflow closes a page that already holds a cluster
        if (open_clusters != '0 && 64'(open_bytes) + cl_bytes > 64'(page_budget)) begin
            expect_result(page_record(1'b0));
            open_number = open_number + 1'b1;
            open_first  = next_index;
            clear_page();
        end
        placed               = '0;
        placed.kind          = KIND_PLACEMENT;
        placed.page_number   = open_number;
        placed.first_cluster = next_index;
        placed.run_end       = !c.final_cluster;
        expect_result(placed);
        // saturating page totals, wrapping index
        if (open_clusters != {INDEX_W{1'b1}}) open_clusters = open_clusters + 1'b1;
        sum = 64'(open_bytes) + cl_bytes;
        if (sum > 64'({BYTES_W{1'b1}})) open_bytes = '1;
        else open_bytes = sum[BYTES_W-1:0];
        for (int i = 0; i < 3; i++) begin
            if ($signed(cl_lo[i]) < $signed(page_lo[i])) page_lo[i] = cl_lo[i];
            if ($signed(cl_hi[i]) > $signed(page_hi[i])) page_hi[i] = cl_hi[i];
        end
        next_index = next_index + 1'b1;
        // last cluster of a mesh flushes the page and restarts
        if (c.final_cluster) begin
            expect_result(page_record(1'b1));
            restart_packer();
        end
    endtask

    // send one cluster request, valid stays high afterwards until an idle gap or drain
    task automatic send_cluster(input in_item_t c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        place_cluster(c);
    endtask

    // stop sending and wait for every queued result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_budget(input logic [BUDGET_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        page_budget = value;
    endtask

    function automatic in_item_t make_cluster(input logic [COUNT_W-1:0] tris,
                                              input logic [COUNT_W-1:0] verts,
                                              input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi,
                                              input logic last);
        in_item_t c;
        c.triangle_count = tris;
        c.vertex_count   = verts;
        c.box_min_x      = lo;
        c.box_min_y      = lo + 1;
        c.box_min_z      = lo + 2;
        c.box_max_x      = hi;
        c.box_max_y      = hi - 1;
        c.box_max_z      = hi - 2;
        c.final_cluster  = last;
        return c;
    endfunction

    // mostly small counts so pages hold several clusters
    function automatic logic [COUNT_W-1:0] random_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return COUNT_W'($urandom_range(0, 3000));
        if (sel < 9) return COUNT_W'($urandom);
        return $urandom_range(0, 1) ? {COUNT_W{1'b1}} : '0;
    endfunction

    function automatic in_item_t random_cluster();
        in_item_t                  c;
        logic signed [COORD_W-1:0] a [3];
        logic signed [COORD_W-1:0] b [3];
        c.triangle_count = random_count();
        c.vertex_count   = random_count();
        for (int i = 0; i < 3; i++) begin
            a[i] = $urandom;
            b[i] = $urandom;
            // mostly well-ordered boxes, some inverted
            if ($urandom_range(0, 3) != 0 && a[i] > b[i]) begin
                a[i] = b[i];
                b[i] = $urandom_range(0, 1) ? HI_EMPTY + 32'(b[i] - HI_EMPTY) : LO_EMPTY;
            end
        end
        c.box_min_x     = a[0];
        c.box_min_y     = a[1];
        c.box_min_z     = a[2];
        c.box_max_x     = b[0];
        c.box_max_y     = b[1];
        c.box_max_z     = b[2];
        c.final_cluster = 1'b0;
        return c;
    endfunction

    function automatic logic [BUDGET_W-1:0] random_budget();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return $urandom;
            default: return 32'($urandom_range(100, 150000));
        endcase
    endfunction

    // reset budget: fill, oversize cluster, inverted box, final flush
    task automatic test_reset_budget();
        send_cluster(make_cluster('0, '0, HI_EMPTY, LO_EMPTY, 1'b0));
        send_cluster(make_cluster(20'd1000, 20'd500, 32'hFFFF_0000, 32'h0001_0000, 1'b0));
        send_cluster(make_cluster(20'd2000, '0, 32'h0000_8000, 32'h0000_9000, 1'b0));
        send_cluster(make_cluster('1, '1, 32'h8000_0010, 32'h7FFF_FFF0, 1'b0));
        send_cluster(make_cluster(20'd1, 20'd1, LO_EMPTY - 2, HI_EMPTY + 2, 1'b0));
        send_cluster(make_cluster('0, '0, 32'h1234_5678, 32'h2345_6789, 1'b1));
        // overflow and final flush on the same request
        send_cluster(make_cluster(20'd5000, '0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
        send_cluster(make_cluster(20'd1000, '0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        // single cluster mesh
        send_cluster(make_cluster(20'hAAAAA, 20'h55555, 32'h0, 32'h0, 1'b1));
        drain();
    endtask

    // zero and unit budgets close a page before every further cluster
    task automatic test_budget_extremes();
        set_budget('0);
        send_cluster(make_cluster('0, '0, 32'h0, 32'h10, 1'b0));
        send_cluster(make_cluster('0, '0, 32'h8, 32'h18, 1'b0));
        send_cluster(make_cluster(20'h55555, 20'hAAAAA, 32'h20, 32'h8, 1'b1));
        drain();
        set_budget(32'd1);
        send_cluster(make_cluster('0, '0, 32'hFFFF_FFFF, 32'h1, 1'b0));
        send_cluster(make_cluster(20'd3, 20'd3, 32'hFFFF_FFFE, 32'h2, 1'b0));
        send_cluster(make_cluster(20'd7, '0, 32'h4, 32'h3, 1'b1));
        drain();
    endtask

    // largest budget filled with largest clusters until one page closes
    task automatic test_full_budget_page();
        set_budget('1);
        for (int i = 0; i < 70; i++) begin
            send_cluster(make_cluster('1, '1, 32'(i) << 20, 32'(i) << 22, i == 69));
        end
        drain();
    endtask

    // random meshes with budget changes between them
    task automatic test_random_meshes();
        int sent;
        int len;
        in_item_t c;
        sent = 0;
        while (sent < 10) begin
            if ($urandom_range(0, 2) == 0) begin
                drain();
                set_budget(random_budget());
            end
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                c = random_cluster();
                c.final_cluster = (i == len - 1) || ($urandom_range(0, 19) == 0);
                send_cluster(c);
                sent++;
            end
        end
        drain();
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        in_item_t c;
        idle_on = 1'b0;
        set_budget(32'd40000);
        for (int i = 0; i < 8; i++) begin
            c = random_cluster();
            c.final_cluster = (i % 4 == 3);
            send_cluster(c);
        end
        drain();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // random result stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result with the oldest one pending
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none pending: kind %0b page %0h", m_data.kind,
                       m_data.page_number);
                errors++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("kind", oldest_result.kind, m_data.kind);
                check_field("page_number", oldest_result.page_number, m_data.page_number);
                check_field("first_cluster", oldest_result.first_cluster,
                            m_data.first_cluster);
                check_field("clusters_in_page", oldest_result.clusters_in_page,
                            m_data.clusters_in_page);
                check_field("page_bytes", oldest_result.page_bytes, m_data.page_bytes);
                check_field("page_min_x", oldest_result.page_min_x, m_data.page_min_x);
                check_field("page_min_y", oldest_result.page_min_y, m_data.page_min_y);
                check_field("page_min_z", oldest_result.page_min_z, m_data.page_min_z);
                check_field("page_max_x", oldest_result.page_max_x, m_data.page_max_x);
                check_field("page_max_y", oldest_result.page_max_y, m_data.page_max_y);
                check_field("page_max_z", oldest_result.page_max_z, m_data.page_max_z);
                check_field("run_end", oldest_result.run_end, m_data.run_end);
            end
        end
    end

    initial begin
        // register comes out of reset at 64 KiB
        page_budget = 32'd65536;
        restart_packer();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_budget();
        test_budget_extremes();
        test_full_budget_page();
        test_random_meshes();
        test_steady_stream();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("next_fit_page_packer regression: pass");
        end else begin
            $display("next_fit_page_packer regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("next_fit_page_packer regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
